@@ rtl/fosm_pkg.sv @@
// ----------------------------------------------------------------------------
// fosm_pkg
// shared types and constants of the first occurrence string matcher
// ----------------------------------------------------------------------------
package fosm_pkg;

  localparam int PAT_BYTES = 16;
  localparam int PAT_BITS  = PAT_BYTES * 8;
  localparam int LEN_W     = 5;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] match_start;
  } result_t;

endpackage

@@ rtl/fosm_cell.sv @@
// ----------------------------------------------------------------------------
// fosm_cell
// one window cell: holds a text byte, passes it on, compares its next value
// ----------------------------------------------------------------------------
module fosm_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  logic                           shift_en,
  input  logic [7:0]                     byte_in,
  output logic [7:0]                     byte_out,
  input  logic [fosm_pkg::PAT_BITS-1:0]  pattern,
  input  logic [fosm_pkg::LEN_W-1:0]     len,
  output logic                           eq
);
  import fosm_pkg::*;

  logic [7:0] data_r;
  logic [3:0] sel;
  logic       active;
  logic [7:0] pat_byte;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= byte_in;
    end
  end

  always_comb begin
    active   = (IDX < int'(len));
    sel      = 4'(int'(len) - 1 - IDX);
    pat_byte = pattern[{sel, 3'b000} +: 8];
    eq       = !active || (byte_in == pat_byte);
  end

  assign byte_out = data_r;

endmodule

@@ rtl/fosm_out_buf.sv @@
// ----------------------------------------------------------------------------
// fosm_out_buf
// two-word output buffer between the match logic and the result channel
// ----------------------------------------------------------------------------
module fosm_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fosm_pkg::result_t  push_data,
  output logic               ready,
  output logic               valid,
  input  logic               pop_ready,
  output fosm_pkg::result_t  head
);
  import fosm_pkg::*;

  result_t head_r, head_nxt;
  result_t tail_r, tail_nxt;
  logic    v0_r, v0_nxt;
  logic    v1_r, v1_nxt;
  logic    pop;

  assign pop   = v0_r && pop_ready;
  assign ready = !v1_r;
  assign valid = v0_r;
  assign head  = head_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    if (pop) begin
      head_nxt = tail_r;
      v0_nxt   = v1_r;
      v1_nxt   = 1'b0;
    end
    if (push) begin
      if (!v0_nxt) begin
        head_nxt = push_data;
        v0_nxt   = 1'b1;
      end else begin
        tail_nxt = push_data;
        v1_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

endmodule

@@ rtl/first_occurrence_string_matcher.sv @@
// ----------------------------------------------------------------------------
// first_occurrence_string_matcher
// reports the start index of the first pattern match in a streamed text
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata[7:0] text byte, tlast marks end of text
//  out_    | master    | tdata[31:0] match start, tuser[0] found
//  cfg_    | slave     | index 0/1 pattern bytes low/high, 2 pattern length
//
//  one text byte per cycle while in_tready is high; each cell compares its
//  byte in the accept cycle and the result word is registered in a two-word
//  output buffer; in_tready drops only while both buffer words are full
//  reset (rst_n low, synchronous) clears the counters and the buffer
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module first_occurrence_string_matcher #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] text_byte
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fosm_pkg::CNT_W-1:0]      out_tdata,  // [31:0] match_start
  output logic                            out_tuser,  // [0] found
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fosm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fosm_pkg::CFG_W-1:0]      cfg_data
);
  import fosm_pkg::*;

  localparam int CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

  logic [CFG_W-1:0] pat_low_r;
  logic [CFG_W-1:0] pat_high_r;
  logic [LEN_W-1:0] pat_len_r;
  logic [LEN_W-1:0] eff_len;
  logic [PAT_BITS-1:0] pattern;

  logic [CNT_W-1:0] seen_r, seen_nxt, seen_inc;
  logic             done_r, done_nxt;
  logic             accept, hit, emit, buf_ready;
  result_t          res;
  result_t          head;

  logic [7:0]             win [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] eq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= LEN_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len = pat_len_r;
    if (pat_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (pat_len_r > CAP_LEN) begin
      eff_len = CAP_LEN;
    end
  end

  assign pattern = {pat_high_r, pat_low_r};
  assign accept  = in_tvalid && in_tready;
  assign win[0]  = in_tdata;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    fosm_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (win[k]),
      .byte_out (win[k+1]),
      .pattern  (pattern),
      .len      (eff_len),
      .eq       (eq[k])
    );
  end

  always_comb begin
    seen_inc = (seen_r == CNT_MAX) ? seen_r : seen_r + CNT_W'(1);
    hit      = !done_r && (seen_inc >= CNT_W'(eff_len)) && (&eq);
    emit     = accept && !done_r && (hit || in_tlast);
    res.found       = hit;
    res.match_start = hit ? (seen_inc - CNT_W'(eff_len)) : '0;
    seen_nxt = seen_r;
    done_nxt = done_r;
    if (accept) begin
      if (in_tlast) begin
        seen_nxt = '0;
        done_nxt = 1'b0;
      end else begin
        seen_nxt = seen_inc;
        done_nxt = done_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      done_r <= done_nxt;
    end
  end

  fosm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (res),
    .ready     (buf_ready),
    .valid     (out_tvalid),
    .pop_ready (out_tready),
    .head      (head)
  );

  assign in_tready = buf_ready;
  assign out_tdata = head.match_start;
  assign out_tuser = head.found;

endmodule

@@ rtl/fosm_checker.sv @@
// ----------------------------------------------------------------------------
// fosm_checker
// port-level checks of the string matcher, bound to the top level
// ----------------------------------------------------------------------------
module fosm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fosm_pkg::CNT_W-1:0]      out_tdata,
  input logic                            out_tuser,
  input logic                            cfg_ready
);
  import fosm_pkg::*;

  // a not-found word carries a zero start index
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found word with nonzero start index");

  // input stalls only behind pending result words
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind first_occurrence_string_matcher fosm_checker u_fosm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);

@@ tb/fosm_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fosm_match_checker
// tracks pattern registers and text window of the matcher, predicts every
// result word from the accepted text words and compares it field by field
// ----------------------------------------------------------------------------
module fosm_match_checker #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [fosm_pkg::CNT_W-1:0]     out_tdata,
  input  logic                           out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fosm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fosm_pkg::CFG_W-1:0]     cfg_data,
  output int                             pending,
  output int                             errors
);
  import fosm_pkg::*;

  logic [PAT_BITS-1:0] pattern;
  logic [LEN_W-1:0]    pat_len;
  logic [7:0]          window [PAT_BYTES];
  logic [CNT_W-1:0]    seen;
  logic                reported;
  result_t             awaited_results [$];
  result_t             head;

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic int active_length();
    int cap;
    int n;
    cap = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    n   = int'(pat_len);
    if (n == 0) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  task automatic clear_text();
    for (int k = 0; k < PAT_BYTES; k++) window[k] = 8'h00;
    seen     = '0;
    reported = 1'b0;
  endtask

  // one text word: shift window, count, compare the active pattern bytes of the window
  task automatic scan_byte(input logic [7:0] b, input logic last);
    int      n;
    bit      hit;
    result_t r;
    for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (seen != CNT_MAX) seen = seen + 1'b1;
    if (!reported) begin
      n   = active_length();
      hit = (seen >= CNT_W'(n));
      for (int k = 0; k < n; k++) begin
        if (window[k] != pattern[8*(n-1-k) +: 8]) hit = 1'b0;
      end
      if (hit) begin
        r.found       = 1'b1;
        r.match_start = seen - CNT_W'(n);
        reported      = 1'b1;
        awaited_results.push_back(r);
      end else if (last) begin
        r = '0;
        awaited_results.push_back(r);
      end
    end
    if (last) clear_text();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pattern = '0;
      pat_len = LEN_W'(1);
      clear_text();
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result word: found %0d match_start %0d", out_tuser, out_tdata);
          errors++;
        end else begin
          head = awaited_results.pop_front();
          if (out_tuser !== head.found) begin
            $error("found: expected %0d, actual %0d", head.found, out_tuser);
            errors++;
          end
          if (out_tdata !== head.match_start) begin
            $error("match_start: expected %0d, actual %0d", head.match_start, out_tdata);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PAT_LOW:  pattern[CFG_W-1:0]        = cfg_data;
          REG_PAT_HIGH: pattern[PAT_BITS-1:CFG_W] = cfg_data;
          REG_PAT_LEN:  pat_len                   = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
    end
    pending = awaited_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// streams directed and random texts through the string matcher under
// several pattern settings, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;
  import fosm_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [CNT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int                   pending;
  int                   errors;
  int                   cycles;
  int                   sent;
  bit                   no_idle;
  logic [PAT_BITS-1:0]  cur_pat;
  int                   cur_len;

  first_occurrence_string_matcher #(.MAX_PATTERN(16)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fosm_match_checker #(.MAX_PATTERN(16)) CHK (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .errors     (errors)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side: random stall before each word
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      out_tready = 1'b0;
      repeat (no_idle ? 0 : $urandom_range(0, 8)) @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = {$urandom, $urandom};
  endtask

  task automatic set_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [LEN_W-1:0] len_raw);
    logic [CFG_W-1:0] lw;
    wait_drained();
    lw = {$urandom, $urandom};
    lw[LEN_W-1:0] = len_raw;
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_PAT_LEN, lw);
    cur_pat = {hi, lo};
    cur_len = (len_raw == 0) ? 1 : (len_raw > PAT_BYTES) ? PAT_BYTES : int'(len_raw);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    repeat (no_idle ? 0 : $urandom_range(0, 8)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    sent++;
  endtask

  // planted pattern, pattern-byte alphabet, near misses or plain noise
  task automatic send_text(input int len);
    int         mode;
    int         off;
    logic [7:0] b;
    mode = $urandom_range(0, 3);
    off  = (len > cur_len) ? $urandom_range(0, len - cur_len) : 0;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin
          if (len >= cur_len && i >= off && i < off + cur_len)
            b = cur_pat[8*(i-off) +: 8];
          else
            b = $urandom;
        end
        1: b = cur_pat[8*$urandom_range(0, cur_len - 1) +: 8];
        2: b = cur_pat[8*$urandom_range(0, cur_len - 1) +: 8] ^ 8'($urandom_range(0, 1));
        default: b = $urandom;
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [LEN_W-1:0] len_raw;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PAT_LOW;
    cfg_data  = '0;
    no_idle   = 1'b0;
    sent      = 0;
    cur_pat   = '0;
    cur_len   = 1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset pattern is a single zero byte
    send_byte(8'h00, 1'b1);

    // length zero acts as one
    set_pattern(64'hFF, 64'h0, 5'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // oversized length caps at sixteen, match on the final word
    set_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
    for (int i = 0; i < PAT_BYTES; i++) send_byte(cur_pat[8*i +: 8], i == PAT_BYTES - 1);

    // text shorter than the pattern
    set_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd4);
    send_byte(cur_pat[7:0], 1'b0);
    send_byte(cur_pat[15:8], 1'b1);

    // length changes in the middle of a text
    set_pattern(64'h4241, 64'h0, 5'd2);
    send_byte(8'h5A, 1'b0);
    set_pattern(64'h4241, 64'h0, 5'd1);
    send_byte(8'h41, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (ph)
        0: begin lo = '1; hi = '1; len_raw = 5'd16; end
        1: begin lo = '0; hi = '0; len_raw = 5'd1; end
        2: len_raw = 5'd0;
        3: len_raw = 5'd31;
        4: len_raw = 5'd17;
        5: len_raw = 5'd16;
        default: len_raw = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(1, 4));
      endcase
      set_pattern(lo, hi, len_raw);
      while (sent < PHASE_ITEMS * (ph + 1) + 24) begin
        no_idle = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0)
          send_text($urandom_range(1, 60));
        else
          send_text($urandom_range(1, 2 * cur_len + 8));
        if ($urandom_range(0, 19) == 0) begin
          do @(negedge clk); while (pending != 0);
        end
      end
      no_idle = 1'b0;
    end

    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
